// ===== rtl/core/dip_pkg.sv =====
package dip_pkg;

    // One request on the character channel.
    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } char_req_t;

    // One request on the result channel.
    typedef struct packed {
        logic [31:0] address;
        logic [1:0]  status;
    } result_t;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_UNUSED = 2'd3;

    // Token phase codes.
    localparam logic [2:0] PH_BETWEEN = 3'd0;
    localparam logic [2:0] PH_LEAD    = 3'd1;
    localparam logic [2:0] PH_SIGN    = 3'd2;
    localparam logic [2:0] PH_DIGITS  = 3'd3;
    localparam logic [2:0] PH_TAIL    = 3'd4;

    // Character codes the parser reacts to.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] OCTET_COUNT = 3'd4;
    localparam logic [2:0] UPPER_COUNT = 3'd3;
    localparam logic [8:0] OCTET_MAX   = 9'd255;
    localparam logic [8:0] OCTET_SAT   = 9'd256;

endpackage

// ===== rtl/core/dotted_ipv4_text_parser.sv =====
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+---------------------------------
// char      | in        | char_valid / char_stall    | char_data   : char_in, last_char
// result    | out       | result_valid / result_stall| result_data : address, status
//
// One character request is taken per cycle unless char_stall is high. Each
// request is held in the input register and is folded into the parse state
// when it advances; a request marked last_char loads its result into the output
// register at that same edge, from which the result is offered. Throughput
// is limited only by the result register: the input stalls just while a last_char
// request waits behind a result that is itself stalled. rst_n clears the parse
// state and both valid flags asynchronously.
module dotted_ipv4_text_parser
    import dip_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_stall,
    input  char_req_t char_data,
    output logic      result_valid,
    input  logic      result_stall,
    output result_t   result_data
);

    // The full parse state of the string currently being read.
    typedef struct packed {
        logic [2:0]  octet_index;
        logic [2:0]  token_phase;
        logic        minus_seen;
        logic [8:0]  octet_value;
        logic [23:0] upper_octets;
        logic [1:0]  error_code;
        logic        string_over;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        octet_index:  3'd0,
        token_phase:  PH_BETWEEN,
        minus_seen:   1'b0,
        octet_value:  9'd0,
        upper_octets: 24'd0,
        error_code:   ST_OK,
        string_over:  1'b0
    };

    // Finishing a token checks its range and, for the first three octets,
    // shifts it into the upper bytes. The fourth stays in octet_value.
    function automatic parse_state_t close_token(input parse_state_t s);
        parse_state_t r;
        r = s;
        if ((s.octet_value > OCTET_MAX) || (s.minus_seen && (s.octet_value != 9'd0))) begin
            r.error_code = ST_RANGE;
        end else if (s.octet_index < UPPER_COUNT) begin
            r.upper_octets = {s.upper_octets[15:0], s.octet_value[7:0]};
            r.octet_value  = 9'd0;
        end
        r.octet_index = s.octet_index + 3'd1;
        r.minus_seen  = 1'b0;
        r.token_phase = PH_BETWEEN;
        return r;
    endfunction

    // Decimal accumulate, saturating at 256 so any oversized octet stays flagged.
    function automatic logic [8:0] add_digit(input logic [8:0] value, input logic [7:0] c);
        logic [11:0] sum;
        sum = ({3'd0, value} * 12'd10) + {8'd0, c[3:0]};
        return (sum > {3'd0, OCTET_SAT}) ? OCTET_SAT : sum[8:0];
    endfunction

    logic         in_valid_reg;
    char_req_t    in_data_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         result_valid_reg;
    result_t      result_reg;
    result_t      result_next;
    logic         advance;
    logic         char_accept;

    // The held request moves on unless it carries a result that has no room.
    assign advance = in_valid_reg &&
                     !(in_data_reg.last_char && result_valid_reg && result_stall);
    assign char_stall  = in_valid_reg && !advance;
    assign char_accept = char_valid && !char_stall;

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    always_comb
    begin
        parse_state_t s;
        parse_state_t f;
        logic [7:0]   c;
        logic         is_sep;
        logic         is_dig;
        s      = state_reg;
        c      = in_data_reg.char_in;
        is_sep = (c == CH_CR) || (c == CH_LF) || (c == CH_SPACE) || (c == CH_DOT);
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);

        // Characters after a zero byte, an error or the fourth token are ignored.
        if (!(s.string_over || (s.error_code != ST_OK) || (s.octet_index >= OCTET_COUNT))) begin
            if (c == CH_NUL) begin
                if (s.token_phase != PH_BETWEEN) begin
                    s = close_token(s);
                end
                s.string_over = 1'b1;
            end else if (is_sep) begin
                if (s.token_phase != PH_BETWEEN) begin
                    s = close_token(s);
                end
            end else begin
                if (s.token_phase == PH_BETWEEN) begin
                    s.token_phase = PH_LEAD;
                    s.minus_seen  = 1'b0;
                    s.octet_value = 9'd0;
                end
                unique case (s.token_phase)
                    PH_LEAD:
                    begin
                        priority if ((c == CH_TAB) || (c == CH_VT) || (c == CH_FF)) begin
                            s.token_phase = PH_LEAD;
                        end else if (c == CH_PLUS) begin
                            s.token_phase = PH_SIGN;
                        end else if (c == CH_MINUS) begin
                            s.minus_seen  = 1'b1;
                            s.token_phase = PH_SIGN;
                        end else if (is_dig) begin
                            s.octet_value = add_digit(s.octet_value, c);
                            s.token_phase = PH_DIGITS;
                        end else begin
                            s.token_phase = PH_TAIL;
                        end
                    end
                    PH_SIGN, PH_DIGITS:
                    begin
                        if (is_dig) begin
                            s.octet_value = add_digit(s.octet_value, c);
                            s.token_phase = PH_DIGITS;
                        end else begin
                            s.token_phase = PH_TAIL;
                        end
                    end
                    default:
                    begin
                        s.token_phase = PH_TAIL;
                    end
                endcase
            end
        end

        // On the last character an open token is closed and the string judged.
        // This works on a copy so that ordinary characters leave the token open.
        f = s;
        if (!f.string_over && (f.error_code == ST_OK) && (f.octet_index < OCTET_COUNT) &&
            (f.token_phase != PH_BETWEEN)) begin
            f = close_token(f);
        end
        if ((f.error_code == ST_OK) && (f.octet_index < OCTET_COUNT)) begin
            f.error_code = ST_SHORT;
        end
        result_next.status  = f.error_code;
        result_next.address = (f.error_code == ST_OK) ?
                              {f.upper_octets, f.octet_value[7:0]} : 32'd0;

        // A finished string starts the next one from the reset state.
        state_next = in_data_reg.last_char ? STATE_RESET : s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg     <= 1'b0;
            state_reg        <= STATE_RESET;
            result_valid_reg <= 1'b0;
        end else begin
            if (char_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance && in_data_reg.last_char) begin
                result_valid_reg <= 1'b1;
            end else if (result_valid_reg && !result_stall) begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_accept) begin
            in_data_reg <= char_data;
        end
        if (advance && in_data_reg.last_char) begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== rtl/core/dip_checker.sv =====
module dip_checker
    import dip_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      char_valid,
    input logic      char_stall,
    input char_req_t char_data,
    input logic      result_valid,
    input logic      result_stall,
    input result_t   result_data
);

    // A stalled result holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // Only the three defined status codes appear, and errors give a zero address.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.status != ST_UNUSED) &&
                         ((result_data.status == ST_OK) || (result_data.address == 32'd0)))
        else $error("bad status or nonzero address on error");

    // A fresh result is driven from the output register after its last character
    // has passed through the input register; the check looks back to the accepting edge.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(char_valid && !char_stall && char_data.last_char, 2))
        else $error("result without a last character");

    // The input stalls only behind a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> result_valid && result_stall)
        else $error("input stalled without back pressure");

endmodule

bind dotted_ipv4_text_parser dip_checker u_dip_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_data    (char_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

// ===== tb/dotted_ipv4_text_parser_tb.sv =====
`timescale 1ns / 1ps

module dotted_ipv4_text_parser_tb;
    import dip_pkg::*;

    // Traffic shapes used by the phases of the run. The hold shape keeps the
    // result side stalled for a long stretch while characters keep coming.
    typedef enum logic [2:0] {
        TRAFFIC_FREE,
        TRAFFIC_SENDER_IDLE,
        TRAFFIC_RECEIVER_STALL,
        TRAFFIC_BOTH,
        TRAFFIC_HOLD
    } traffic_t;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_BYTES  = 180;
    localparam int HOLD_STRINGS = 30;
    localparam int DRAIN_CYCLES = 10;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      char_valid = 1'b0;
    logic      char_stall;
    char_req_t char_data = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    result_t   result_data;

    dotted_ipv4_text_parser uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // Character requests waiting to be driven, the text of the string that is
    // being built, and the addresses the parser is expected to return.
    char_req_t   char_requests[$];
    logic [7:0]  text_buf[$];
    result_t     expected_addresses[$];

    traffic_t traffic = TRAFFIC_FREE;
    logic     char_taken = 1'b0;
    int       mismatch_count = 0;
    int       quiet_cycles = 0;
    int       phase_bytes = 0;

    // Shadow copy of the parse state, updated once per accepted request.
    logic [2:0]  octets_done;
    logic [2:0]  token_state;
    logic        neg_sign;
    logic [8:0]  octet_acc;
    logic [23:0] upper_octets;
    logic [1:0]  fault;
    logic        nul_seen;

    initial begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Address prediction
    // ------------------------------------------------------------------

    task automatic clear_parse();
        octets_done  = '0;
        token_state  = PH_BETWEEN;
        neg_sign     = 1'b0;
        octet_acc    = '0;
        upper_octets = '0;
        fault        = ST_OK;
        nul_seen     = 1'b0;
    endtask

    // Closing a token either records a range error or shifts the octet into
    // the upper bytes. The fourth octet stays in the accumulator.
    task automatic close_octet();
        if (octet_acc > OCTET_MAX || (neg_sign && octet_acc != '0)) begin
            fault = ST_RANGE;
        end else if (octets_done < UPPER_COUNT) begin
            upper_octets = {upper_octets[15:0], octet_acc[7:0]};
            octet_acc = '0;
        end
        octets_done = octets_done + 3'd1;
        neg_sign    = 1'b0;
        token_state = PH_BETWEEN;
    endtask

    // The accumulator saturates at 256 so that long digit runs stay within its nine bits.
    task automatic push_digit(input logic [7:0] c);
        int v;
        v = int'(octet_acc) * 10 + int'(c) - int'(CH_ZERO);
        octet_acc = (v > int'(OCTET_SAT)) ? OCTET_SAT : v[8:0];
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic is_digit;
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        // Nothing moves after a terminator, after an error, or after four tokens.
        if (nul_seen || fault != ST_OK || octets_done >= OCTET_COUNT) begin
            return;
        end
        if (c == CH_NUL) begin
            if (token_state != PH_BETWEEN) begin
                close_octet();
            end
            nul_seen = 1'b1;
            return;
        end
        if (c == CH_CR || c == CH_LF || c == CH_SPACE || c == CH_DOT) begin
            if (token_state != PH_BETWEEN) begin
                close_octet();
            end
            return;
        end
        if (token_state == PH_BETWEEN) begin
            token_state = PH_LEAD;
            neg_sign    = 1'b0;
            octet_acc   = '0;
        end
        case (token_state)
            PH_LEAD:
            begin
                if (c == CH_TAB || c == CH_VT || c == CH_FF) begin
                    // Leading blanks inside a token are skipped.
                end else if (c == CH_PLUS) begin
                    token_state = PH_SIGN;
                end else if (c == CH_MINUS) begin
                    neg_sign    = 1'b1;
                    token_state = PH_SIGN;
                end else if (is_digit) begin
                    push_digit(c);
                    token_state = PH_DIGITS;
                end else begin
                    token_state = PH_TAIL;
                end
            end
            PH_SIGN, PH_DIGITS:
            begin
                if (is_digit) begin
                    push_digit(c);
                    token_state = PH_DIGITS;
                end else begin
                    token_state = PH_TAIL;
                end
            end
            default:
            begin
                token_state = PH_TAIL;
            end
        endcase
    endtask

    // Folds one accepted request into the shadow state. A request marked last
    // closes any open token, settles the status and queues the address.
    task automatic predict_address(input char_req_t req);
        result_t res;
        parse_char(req.char_in);
        if (req.last_char) begin
            if (!nul_seen && fault == ST_OK && octets_done < OCTET_COUNT &&
                token_state != PH_BETWEEN) begin
                close_octet();
            end
            if (fault == ST_OK && octets_done < OCTET_COUNT) begin
                fault = ST_SHORT;
            end
            res.status  = fault;
            res.address = (fault == ST_OK) ? {upper_octets, octet_acc[7:0]} : '0;
            expected_addresses.push_back(res);
            clear_parse();
        end
    endtask

    // ------------------------------------------------------------------
    // Text building
    // ------------------------------------------------------------------

    task automatic add_byte(input logic [7:0] c);
        text_buf.push_back(c);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_buf.push_back(s[i]);
        end
    endtask

    // Moves the built string into the request queue, marking its final byte.
    task automatic commit_string();
        char_req_t req;
        if (text_buf.size() == 0) begin
            text_buf.push_back(8'($urandom_range(0, 255)));
        end
        while (text_buf.size() > 0) begin
            req.char_in   = text_buf.pop_front();
            req.last_char = (text_buf.size() == 0);
            char_requests.push_back(req);
            phase_bytes++;
        end
    endtask

    task automatic add_separator();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        repeat (n) begin
            case ($urandom_range(0, 9))
                0: add_byte(CH_CR);
                1: add_byte(CH_LF);
                2: add_byte(CH_SPACE);
                default: add_byte(CH_DOT);
            endcase
        end
    endtask

    // One token with mostly in-range octets, and now and then leading blanks,
    // a sign, leading zeros, an oversized value, no digits or trailing junk.
    task automatic add_random_token();
        int r;
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
                0: add_byte(CH_TAB);
                1: add_byte(CH_VT);
                default: add_byte(CH_FF);
            endcase
        end
        r = $urandom_range(0, 19);
        if (r == 0) begin
            add_byte(CH_MINUS);
        end else if (r == 1) begin
            add_byte(CH_PLUS);
        end
        r = $urandom_range(0, 99);
        if (r < 75) begin
            add_text($sformatf("%0d", $urandom_range(0, 255)));
        end else if (r < 83) begin
            add_text($sformatf("%0d", $urandom_range(256, 99999)));
        end else if (r < 90) begin
            add_text({"00", $sformatf("%0d", $urandom_range(0, 99))});
        end else if (r < 95) begin
            add_text($sformatf("%0d", $urandom_range(0, 3)));
        end
        if ($urandom_range(0, 11) == 0) begin
            add_byte(8'($urandom_range(8'h41, 8'h7A)));
            if ($urandom_range(0, 1) == 1) begin
                add_text($sformatf("%0d", $urandom_range(0, 9)));
            end
        end
    endtask

    // One random string: mostly a dotted address with random content, the rest
    // short addresses, addresses with extra text or a terminator, or noise.
    task automatic build_random_address();
        int r;
        int tokens;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 10)) begin
                add_byte(8'($urandom_range(0, 255)));
            end
        end else begin
            tokens = (r < 16) ? $urandom_range(0, 3) : 4;
            if ($urandom_range(0, 9) == 0) begin
                add_separator();
            end
            for (int i = 0; i < tokens; i++) begin
                add_random_token();
                if (i < tokens - 1) begin
                    add_separator();
                end
            end
            if (r >= 90) begin
                add_separator();
                if ($urandom_range(0, 1) == 1) begin
                    add_byte(CH_NUL);
                end
                repeat ($urandom_range(1, 6)) begin
                    add_byte(8'($urandom_range(0, 255)));
                end
            end else if (r >= 84) begin
                add_separator();
            end
        end
        commit_string();
    endtask

    task automatic wait_idle();
        while (char_requests.size() != 0 || char_valid || expected_addresses.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Character driver: a request stays on the bus until it is accepted.
    // Whether to idle is decided only when a new request would be loaded,
    // so char_valid never looks at char_stall.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        logic idle;
        if (rst_n) begin
            if (!char_valid || char_taken) begin
                case (traffic)
                    TRAFFIC_SENDER_IDLE: idle = ($urandom_range(0, 99) < 53);
                    TRAFFIC_BOTH:        idle = ($urandom_range(0, 99) < 11);
                    default:             idle = 1'b0;
                endcase
                if (char_requests.size() != 0 && !idle) begin
                    char_data  <= char_requests.pop_front();
                    char_valid <= 1'b1;
                end else begin
                    char_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result stall: random per phase. On entry to the hold phase the stall
    // is kept high for a long stretch counted here, so the parser fills up
    // and must stall its character input.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        static int  hold_left = 0;
        static bit  hold_done = 1'b0;
        if (rst_n) begin
            if (traffic == TRAFFIC_HOLD && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_stall <= 1'b1;
            end else begin
                case (traffic)
                    TRAFFIC_RECEIVER_STALL: result_stall <= ($urandom_range(0, 99) < 53);
                    TRAFFIC_BOTH:           result_stall <= ($urandom_range(0, 99) < 11);
                    default:                result_stall <= 1'b0;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted character request, checks every
    // accepted result against the oldest expected address, and runs the
    // watchdog on cycles where neither channel moves.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            char_taken <= char_valid && !char_stall;
            if (char_valid && !char_stall) begin
                predict_address(char_data);
            end
            if (result_valid && !result_stall) begin
                if (expected_addresses.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h/%0d",
                             $time, result_data.address, result_data.status);
                    mismatch_count++;
                end else begin
                    want = expected_addresses.pop_front();
                    if (result_data.address !== want.address) begin
                        $display("%0t: address mismatch, expected %h, actual %h",
                                 $time, want.address, result_data.address);
                        mismatch_count++;
                    end
                    if (result_data.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, result_data.status);
                        mismatch_count++;
                    end
                end
            end
            if ((char_valid && !char_stall) || (result_valid && !result_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
                $display("TB_ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed strings, then random strings under each
    // traffic shape, then the long hold, then drain and report.
    // ------------------------------------------------------------------
    initial begin
        clear_parse();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Plain addresses at the octet extremes.
        add_text("192.168.1.1");
        commit_string();
        add_text("0.0.0.0");
        commit_string();
        add_text("255.255.255.255");
        commit_string();
        // Range errors: just above 255, a saturating digit run, a negative octet,
        // and an error in a later token.
        add_text("256.1.1.1");
        commit_string();
        add_text("99999.1.1.1");
        commit_string();
        add_text("-1.2.3.4");
        commit_string();
        add_text("1.2.300.4");
        commit_string();
        // Signs: minus zero and plus are fine, a bare sign reads as zero.
        add_text("-0.+5.6.7");
        commit_string();
        add_text("1.2.3.-");
        commit_string();
        // Too few tokens, including an empty string and a lone sign.
        add_text("1.2.3");
        commit_string();
        add_byte(CH_NUL);
        commit_string();
        add_text("-");
        commit_string();
        // Leading blanks inside a token and runs of mixed separators.
        add_byte(CH_TAB);
        add_byte(CH_VT);
        add_byte(CH_FF);
        add_text("12");
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_text(" ..3..4 ");
        add_byte(CH_FF);
        add_text("5");
        commit_string();
        // Trailing junk in tokens, tokens with no digits, and a top-bit byte.
        add_text("12a.3b.4.5");
        commit_string();
        add_text("a.b.c.d");
        commit_string();
        add_byte(8'hFF);
        add_text(".1.2.3");
        commit_string();
        // Extra text after the fourth token, and a string that ends on a space.
        add_text("1.2.3.4.5 x");
        commit_string();
        add_text("10.20.30.40 ");
        commit_string();
        // A terminator ends the string early, so the rest is ignored.
        add_text("1.2");
        add_byte(CH_NUL);
        add_text(".3.4");
        commit_string();
        wait_idle();

        traffic = TRAFFIC_FREE;
        phase_bytes = 0;
        while (phase_bytes < PHASE_BYTES) build_random_address();
        wait_idle();

        traffic = TRAFFIC_SENDER_IDLE;
        phase_bytes = 0;
        while (phase_bytes < PHASE_BYTES) build_random_address();
        wait_idle();

        traffic = TRAFFIC_RECEIVER_STALL;
        phase_bytes = 0;
        while (phase_bytes < PHASE_BYTES) build_random_address();
        wait_idle();

        traffic = TRAFFIC_BOTH;
        phase_bytes = 0;
        while (phase_bytes < PHASE_BYTES) build_random_address();
        wait_idle();

        // Queue many strings before the hold starts so characters keep being
        // offered while results back up.
        repeat (HOLD_STRINGS) build_random_address();
        traffic = TRAFFIC_HOLD;
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_addresses.size() != 0) begin
            $display("%0t: %0d expected addresses never arrived",
                     $time, expected_addresses.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/dip_pkg.sv
rtl/core/dotted_ipv4_text_parser.sv
rtl/core/dip_checker.sv
tb/dotted_ipv4_text_parser_tb.sv
